// ===== src/mqmm_pkg.sv =====
// Package for the multi-queue membership manager: sizes, codes, payload types.
// No dependencies.
`default_nettype none
package mqmm_pkg;
   localparam int NUM_QUEUES = 16;
   localparam int CAPACITY = 64;
   localparam int ID_WIDTH = 16;
   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int LINK_W = SLOT_W + 1;
   localparam int QIDX_W = $clog2(NUM_QUEUES);
   localparam int LEN_W = 7;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

   localparam logic [2:0] KIND_ADD = 3'd0;
   localparam logic [2:0] KIND_MOVE = 3'd1;
   localparam logic [2:0] KIND_QUERY = 3'd2;
   localparam logic [2:0] KIND_COUNT = 3'd3;
   localparam logic [2:0] KIND_LIST = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_DUP = 3'd1;
   localparam logic [2:0] ST_NOQ = 3'd2;
   localparam logic [2:0] ST_NOMEM = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;

   // slot entry: id, queue, prev, next (valid bits kept in flops)
   localparam int ENTRY_W = ID_WIDTH + QIDX_W + 2 * LINK_W;

   typedef struct packed {
      logic [2:0] kind;
      logic [15:0] member_id;
      logic [7:0] queue_num;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] queue_out;
      logic [6:0] length;
      logic [15:0] member_out;
      logic list_empty;
      logic last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/mqmm_if.sv =====
// Valid/ready channel interface carrying one payload beat.
// Depends on mqmm_pkg for payload types.
`default_nettype none
interface mqmm_req_if import mqmm_pkg::*; ();
   logic valid;
   logic ready;
   req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface mqmm_rsp_if import mqmm_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/mqmm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mqmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/multi_queue_membership_manager.sv =====
// Top level of the multi-queue membership manager: sequencer around the slot RAM.
// Depends on mqmm_pkg, mqmm_if and mqmm_ram.
//
//  channel | dir | handshake        | content
//  req     | in  | valid/ready      | kind, member_id, queue_num
//  rsp     | out | valid/ready      | status, queue_out, length, member_out, list_empty, last
//  csr     | in  | write enable     | num_queues
//
// One item at a time. ID search scans the slot RAM one slot a cycle. Query, add and
// move respond after the search; count and list skip it; list gives its members one
// by one, walking from the tail. Link updates are one RAM write per cycle.
// Reset is synchronous; no clearing pass (valid bits live in flops).
// A stalled response holds the sequencer and the request side.
`default_nettype none
module multi_queue_membership_manager import mqmm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   mqmm_req_if.sink req,
   mqmm_rsp_if.source rsp,
   input wire logic csr_wr_en,
   input wire logic [4:0] csr_wr_data
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_SCANW = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_RDSELF = 4'd4;
   localparam logic [3:0] S_UNLP = 4'd5;
   localparam logic [3:0] S_UNLN = 4'd6;
   localparam logic [3:0] S_APPEND = 4'd7;
   localparam logic [3:0] S_APTAIL = 4'd8;
   localparam logic [3:0] S_RESP = 4'd9;
   localparam logic [3:0] S_WALKR = 4'd10;
   localparam logic [3:0] S_WALKW = 4'd11;
   localparam logic [3:0] S_RDP = 4'd12;
   localparam logic [3:0] S_RDN = 4'd13;

   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic [QIDX_W-1:0] queue;
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] next;
   } entry_type;

   logic [3:0] state_ff, state_in;
   logic [4:0] numq_ff;
   req_type cmd_ff;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [LINK_W-1:0] heads_ff [NUM_QUEUES];
   logic [LINK_W-1:0] tails_ff [NUM_QUEUES];
   logic [LEN_W-1:0] lens_ff [NUM_QUEUES];
   logic [LINK_W-1:0] scan_ff, scan_in;
   logic [LINK_W-1:0] found_ff, found_in;
   logic [LINK_W-1:0] walk_ff, walk_in;
   entry_type self_ff, self_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic wr_en;
   logic [SLOT_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   mqmm_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_slots (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic queue_ok;
   logic [QIDX_W-1:0] qn;
   logic [SLOT_W-1:0] free_slot;
   logic any_free;
   logic [LINK_W-1:0] scan_prev;
   logic [SLOT_W-1:0] fnd;
   logic hd_we, tl_we, len_inc, len_dec;
   logic [QIDX_W-1:0] hd_q, tl_q, len_q;
   logic [LINK_W-1:0] hd_v, tl_v;

   assign qn = cmd_ff.queue_num[QIDX_W-1:0];
   assign queue_ok = ({3'b0, cmd_ff.queue_num} < {6'b0, numq_ff})
      && ({3'b0, cmd_ff.queue_num} < 11'(NUM_QUEUES));
   assign fnd = found_ff[SLOT_W-1:0];
   assign scan_prev = scan_ff - LINK_W'(1);

   always_comb begin
      free_slot = '0;
      any_free = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i);
            any_free = 1'b1;
         end
      end
   end

   function automatic rsp_type mk(input logic [2:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      walk_in = walk_ff;
      self_in = self_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      rd_addr = scan_ff[SLOT_W-1:0];
      hd_we = 1'b0; hd_q = qn; hd_v = NIL;
      tl_we = 1'b0; tl_q = qn; tl_v = NIL;
      len_inc = 1'b0; len_dec = 1'b0; len_q = qn;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               scan_in = '0;
               found_in = NIL;
               if (req.payload.kind == KIND_ADD || req.payload.kind == KIND_MOVE
                     || req.payload.kind == KIND_QUERY) begin
                  state_in = S_SCAN;
               end else if (req.payload.kind == KIND_COUNT
                     || req.payload.kind == KIND_LIST) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_SCAN: begin
            // read address scan_ff issued; data arrives next cycle
            rd_addr = scan_ff[SLOT_W-1:0];
            scan_in = scan_ff + LINK_W'(1);
            state_in = S_SCANW;
         end
         S_SCANW: begin
            rd_addr = scan_ff[SLOT_W-1:0];
            if (valid_ff[scan_prev[SLOT_W-1:0]]
                  && rd_data.id == cmd_ff.member_id[ID_WIDTH-1:0]) begin
               found_in = scan_prev;
               self_in = rd_data;
               state_in = S_DECIDE;
            end else if (scan_ff == NIL) begin
               state_in = S_DECIDE;
            end else begin
               scan_in = scan_ff + LINK_W'(1);
            end
         end
         S_DECIDE: begin
            case (cmd_ff.kind)
               KIND_ADD: begin
                  if (found_ff != NIL) begin
                     rsp_in = mk(ST_DUP); state_in = S_RESP;
                  end else if (!queue_ok) begin
                     rsp_in = mk(ST_NOQ); state_in = S_RESP;
                  end else if (!any_free) begin
                     rsp_in = mk(ST_FULL); state_in = S_RESP;
                  end else begin
                     found_in = {1'b0, free_slot};
                     valid_in[free_slot] = 1'b1;
                     self_in.id = cmd_ff.member_id[ID_WIDTH-1:0];
                     state_in = S_APPEND;
                  end
               end
               KIND_MOVE: begin
                  if (!queue_ok) begin
                     rsp_in = mk(ST_NOQ); state_in = S_RESP;
                  end else if (found_ff == NIL) begin
                     rsp_in = mk(ST_NOMEM); state_in = S_RESP;
                  end else if (self_ff.queue == qn) begin
                     rsp_in = mk(ST_OK); state_in = S_RESP;
                  end else begin
                     rd_addr = self_ff.prev[SLOT_W-1:0];
                     state_in = S_RDP;
                  end
               end
               KIND_QUERY: begin
                  if (found_ff == NIL) begin
                     rsp_in = mk(ST_NOMEM);
                  end else begin
                     rsp_in = mk(ST_OK);
                     rsp_in.queue_out = 4'(self_ff.queue);
                  end
                  state_in = S_RESP;
               end
               KIND_COUNT: begin
                  rsp_in = mk(queue_ok ? ST_OK : ST_NOQ);
                  if (queue_ok) begin
                     rsp_in.length = lens_ff[qn];
                  end
                  state_in = S_RESP;
               end
               default: begin
                  if (!queue_ok) begin
                     rsp_in = mk(ST_NOQ); state_in = S_RESP;
                  end else if (tails_ff[qn] == NIL) begin
                     rsp_in = mk(ST_OK); rsp_in.list_empty = 1'b1;
                     state_in = S_RESP;
                  end else begin
                     walk_in = tails_ff[qn];
                     state_in = S_WALKR;
                  end
               end
            endcase
         end
         S_RDP: begin
            rd_addr = self_ff.prev[SLOT_W-1:0];
            state_in = S_UNLP;
         end
         S_UNLP: begin
            // prev.next = next
            if (self_ff.prev != NIL) begin
               wr_en = 1'b1;
               wr_addr = self_ff.prev[SLOT_W-1:0];
               wr_data = rd_data;
               wr_data.next = self_ff.next;
            end else begin
               hd_we = 1'b1; hd_q = self_ff.queue; hd_v = self_ff.next;
            end
            rd_addr = self_ff.next[SLOT_W-1:0];
            state_in = S_RDN;
         end
         S_RDN: begin
            rd_addr = self_ff.next[SLOT_W-1:0];
            state_in = S_UNLN;
         end
         S_UNLN: begin
            if (self_ff.next != NIL) begin
               wr_en = 1'b1;
               wr_addr = self_ff.next[SLOT_W-1:0];
               wr_data = rd_data;
               wr_data.prev = self_ff.prev;
            end else begin
               tl_we = 1'b1; tl_q = self_ff.queue; tl_v = self_ff.prev;
            end
            len_dec = 1'b1; len_q = self_ff.queue;
            state_in = S_APPEND;
         end
         S_APPEND: begin
            // write self as new tail, read old tail
            wr_en = 1'b1;
            wr_addr = fnd;
            wr_data.id = self_ff.id;
            wr_data.queue = qn;
            wr_data.prev = tails_ff[qn];
            wr_data.next = NIL;
            self_in.prev = tails_ff[qn];
            rd_addr = tails_ff[qn][SLOT_W-1:0];
            state_in = S_APTAIL;
         end
         S_APTAIL: begin
            if (self_ff.prev != NIL) begin
               wr_en = 1'b1;
               wr_addr = self_ff.prev[SLOT_W-1:0];
               wr_data = rd_data;
               wr_data.next = found_ff;
            end else begin
               hd_we = 1'b1; hd_v = found_ff;
            end
            tl_we = 1'b1; tl_v = found_ff;
            len_inc = 1'b1;
            rsp_in = mk(ST_OK);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WALKR: begin
            rd_addr = walk_ff[SLOT_W-1:0];
            state_in = S_WALKW;
         end
         S_WALKW: begin
            rd_addr = walk_ff[SLOT_W-1:0];
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.member_out = 16'(rd_data.id);
               rsp_in.last = (rd_data.prev == NIL);
               walk_in = rd_data.prev;
               state_in = (rd_data.prev == NIL) ? S_IDLE : S_WALKR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         numq_ff <= 5'd1;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            heads_ff[i] <= NIL;
            tails_ff[i] <= NIL;
            lens_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            numq_ff <= csr_wr_data;
         end
         if (hd_we) begin
            heads_ff[hd_q] <= hd_v;
         end
         if (tl_we) begin
            tails_ff[tl_q] <= tl_v;
         end
         if (len_inc) begin
            lens_ff[len_q] <= lens_ff[len_q] + LEN_W'(1);
         end else if (len_dec) begin
            lens_ff[len_q] <= lens_ff[len_q] - LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         cmd_ff <= req.payload;
      end
      scan_ff <= scan_in;
      found_ff <= found_in;
      walk_ff <= walk_in;
      self_ff <= self_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

// ===== src/mqmm_checker.sv =====
// Port-level checker for the membership manager, bound to the top level.
// Depends on mqmm_pkg and the top level's ports.
`default_nettype none
module mqmm_checker import mqmm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rsp_type rsp_payload
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken with response pending");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= ST_FULL)
      else $error("bad status");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.last)
      else $error("error beat not last");
endmodule

bind multi_queue_membership_manager mqmm_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for multi_queue_membership_manager: directed table, then random traffic.
// Depends on mqmm_pkg and the mqmm_req_if / mqmm_rsp_if interfaces; self-checking.
`default_nettype none
module tb_top;
   import mqmm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = '0;

   mqmm_req_if req_ch ();
   mqmm_rsp_if rsp_ch ();

   multi_queue_membership_manager u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // shadow of the block
   logic slot_used [CAPACITY];
   logic [ID_WIDTH-1:0] slot_id [CAPACITY];
   logic [3:0] slot_queue [CAPACITY];
   int slot_prev [CAPACITY];
   int slot_next [CAPACITY];
   int q_head [NUM_QUEUES];
   int q_tail [NUM_QUEUES];
   int q_len [NUM_QUEUES];
   int queues_on;

   rsp_type expected_rsps [$];
   int errors = 0;
   logic rsp_hold = 1'b0;
   logic no_idle = 1'b0;

   function automatic rsp_type mk(logic [2:0] st, logic [3:0] qo, logic [6:0] ln,
                                  logic [15:0] mem, logic emp, logic lst);
      rsp_type r;
      r.status = st; r.queue_out = qo; r.length = ln;
      r.member_out = mem; r.list_empty = emp; r.last = lst;
      return r;
   endfunction

   function automatic void expect_beat(rsp_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic int find_member(logic [15:0] id);
      for (int i = 0; i < CAPACITY; i++)
         if (slot_used[i] && slot_id[i] == id) return i;
      return CAPACITY;
   endfunction

   function automatic bit queue_valid(logic [7:0] q);
      return int'(q) < queues_on && int'(q) < NUM_QUEUES;
   endfunction

   function automatic void link_tail(int s, int q);
      slot_queue[s] = q[3:0];
      slot_prev[s] = q_tail[q];
      slot_next[s] = CAPACITY;
      if (q_tail[q] < CAPACITY) slot_next[q_tail[q]] = s;
      else q_head[q] = s;
      q_tail[q] = s;
      q_len[q]++;
   endfunction

   function automatic void unlink(int s);
      int q, p, n;
      q = slot_queue[s]; p = slot_prev[s]; n = slot_next[s];
      if (p < CAPACITY) slot_next[p] = n; else q_head[q] = n;
      if (n < CAPACITY) slot_prev[n] = p; else q_tail[q] = p;
      q_len[q]--;
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < CAPACITY; i++) begin
         slot_used[i] = 0; slot_id[i] = '0; slot_queue[i] = '0;
         slot_prev[i] = CAPACITY; slot_next[i] = CAPACITY;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
         q_head[i] = CAPACITY; q_tail[i] = CAPACITY; q_len[i] = 0;
      end
      queues_on = 1;
   endfunction

   // appends the responses this request causes
   function automatic void predict_rsps(req_type r);
      int s, w, n;
      case (r.kind)
         KIND_ADD: begin
            if (find_member(r.member_id) != CAPACITY) expect_beat(mk(ST_DUP, 0, 0, 0, 0, 1));
            else if (!queue_valid(r.queue_num)) expect_beat(mk(ST_NOQ, 0, 0, 0, 0, 1));
            else begin
               s = 0;
               while (s < CAPACITY && slot_used[s]) s++;
               if (s >= CAPACITY) expect_beat(mk(ST_FULL, 0, 0, 0, 0, 1));
               else begin
                  slot_used[s] = 1; slot_id[s] = r.member_id;
                  link_tail(s, r.queue_num);
                  expect_beat(mk(ST_OK, 0, 0, 0, 0, 1));
               end
            end
         end
         KIND_MOVE: begin
            s = find_member(r.member_id);
            if (!queue_valid(r.queue_num)) expect_beat(mk(ST_NOQ, 0, 0, 0, 0, 1));
            else if (s == CAPACITY) expect_beat(mk(ST_NOMEM, 0, 0, 0, 0, 1));
            else begin
               if (int'(slot_queue[s]) != int'(r.queue_num)) begin
                  unlink(s);
                  link_tail(s, r.queue_num);
               end
               expect_beat(mk(ST_OK, 0, 0, 0, 0, 1));
            end
         end
         KIND_QUERY: begin
            s = find_member(r.member_id);
            if (s == CAPACITY) expect_beat(mk(ST_NOMEM, 0, 0, 0, 0, 1));
            else expect_beat(mk(ST_OK, slot_queue[s], 0, 0, 0, 1));
         end
         KIND_COUNT: begin
            if (!queue_valid(r.queue_num)) expect_beat(mk(ST_NOQ, 0, 0, 0, 0, 1));
            else expect_beat(mk(ST_OK, 0, 7'(q_len[r.queue_num]), 0, 0, 1));
         end
         KIND_LIST: begin
            if (!queue_valid(r.queue_num)) expect_beat(mk(ST_NOQ, 0, 0, 0, 0, 1));
            else if (q_tail[r.queue_num] >= CAPACITY)
               expect_beat(mk(ST_OK, 0, 0, 0, 1, 1));
            else begin
               w = q_tail[r.queue_num]; n = 0;
               while (w < CAPACITY && n < CAPACITY) begin
                  expect_beat(mk(ST_OK, 0, 0, slot_id[w], 0,
                                 slot_prev[w] >= CAPACITY));
                  w = slot_prev[w]; n++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response beat %p", rsp_ch.payload);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_ch.payload.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_ch.payload.status); errors++;
            end
            if (rsp_ch.payload.queue_out !== e.queue_out) begin
               $error("queue_out exp %0d got %0d", e.queue_out, rsp_ch.payload.queue_out);
               errors++;
            end
            if (rsp_ch.payload.length !== e.length) begin
               $error("length exp %0d got %0d", e.length, rsp_ch.payload.length); errors++;
            end
            if (rsp_ch.payload.member_out !== e.member_out) begin
               $error("member_out exp %0h got %0h", e.member_out, rsp_ch.payload.member_out);
               errors++;
            end
            if (rsp_ch.payload.list_empty !== e.list_empty) begin
               $error("list_empty exp %0b got %0b", e.list_empty, rsp_ch.payload.list_empty);
               errors++;
            end
            if (rsp_ch.payload.last !== e.last) begin
               $error("last exp %0b got %0b", e.last, rsp_ch.payload.last); errors++;
            end
         end
      end
   end

   // response ready: random idling, plus a long hold-off when requested
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (rsp_hold) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= no_idle || ($urandom_range(99) >= 21);
   end

   initial begin
      #3000000;
      $display("FAIL multi_queue_membership_manager");
      $finish;
   end

   task automatic send_req(logic [2:0] kind, logic [15:0] id, logic [7:0] qn);
      req_type r;
      r.kind = kind; r.member_id = id; r.queue_num = qn;
      // valid dropped at the previous accept edge
      @(posedge clock);
      while (!no_idle && $urandom_range(99) < 21) @(posedge clock);
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      predict_rsps(r);
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (CAPACITY + 10) @(posedge clock);
   endtask

   task automatic write_queues(logic [4:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      queues_on = (int'(v) > NUM_QUEUES) ? NUM_QUEUES : int'(v);
   endtask

   typedef struct {
      logic [2:0] kind;
      logic [15:0] id;
      logic [7:0] qn;
      bit typed;
      logic [2:0] st;
   } dir_row_type;

   task automatic random_phase(int count, int id_span);
      logic [2:0] k;
      logic [15:0] id;
      logic [7:0] qn;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 35) k = KIND_ADD;
         else if (r < 60) k = KIND_MOVE;
         else if (r < 75) k = KIND_QUERY;
         else if (r < 85) k = KIND_COUNT;
         else if (r < 96) k = KIND_LIST;
         else k = 3'($urandom_range(7, 5));
         id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(id_span));
         qn = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(queues_on));
         send_req(k, id, qn);
      end
   endtask

   initial begin
      dir_row_type tbl [$];
      int got;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      shadow_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset only queue 0 exists
      tbl = '{
         '{KIND_COUNT, 16'h0000, 8'd0, 1, ST_OK},
         '{KIND_LIST, 16'h0000, 8'd0, 1, ST_OK},
         '{KIND_QUERY, 16'hFFFF, 8'd0, 1, ST_NOMEM},
         '{KIND_MOVE, 16'h1234, 8'd0, 1, ST_NOMEM},
         '{KIND_ADD, 16'h0001, 8'd1, 1, ST_NOQ},
         '{KIND_ADD, 16'h0000, 8'd0, 1, ST_OK},
         '{KIND_ADD, 16'hFFFF, 8'd0, 1, ST_OK},
         '{KIND_ADD, 16'hFFFF, 8'd0, 1, ST_DUP},
         '{KIND_ADD, 16'hFFFF, 8'hFF, 1, ST_DUP},
         '{KIND_MOVE, 16'h0000, 8'hFF, 1, ST_NOQ},
         '{KIND_MOVE, 16'h0000, 8'd0, 1, ST_OK},
         '{KIND_COUNT, 16'h0000, 8'd0, 0, ST_OK},
         '{KIND_LIST, 16'h0000, 8'd0, 0, ST_OK},
         '{KIND_LIST, 16'h0000, 8'h80, 1, ST_NOQ},
         '{KIND_COUNT, 16'h0000, 8'd1, 1, ST_NOQ},
         '{3'd5, 16'hAAAA, 8'd0, 0, ST_OK},
         '{3'd7, 16'h5555, 8'hFF, 0, ST_OK},
         '{KIND_QUERY, 16'h0000, 8'd0, 0, ST_OK}
      };
      foreach (tbl[i]) begin
         got = expected_rsps.size();
         send_req(tbl[i].kind, tbl[i].id, tbl[i].qn);
         if (tbl[i].typed && expected_rsps.size() > got &&
             expected_rsps[got].status !== tbl[i].st) begin
            $error("status exp %0d got %0d (table row %0d)", tbl[i].st,
                   expected_rsps[got].status, i);
            errors++;
         end
      end
      drain();

      // full range of queues; moves across queues and list walks
      write_queues(5'd16);
      for (int q = 1; q < 16; q++) send_req(KIND_ADD, 16'(16'h0100 + q), 8'(q));
      send_req(KIND_MOVE, 16'hFFFF, 8'd15);
      send_req(KIND_MOVE, 16'h0000, 8'd15);
      send_req(KIND_LIST, 16'h0000, 8'd15);
      send_req(KIND_ADD, 16'h0200, 8'd16);
      drain();

      // fill the store, with the response side held off so the input backs up
      write_queues(5'd3);
      fork
         begin
            rsp_hold = 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 50; i++) send_req(KIND_ADD, 16'(16'h3000 + i), 8'(i % 3));
      join
      send_req(KIND_ADD, 16'h4000, 8'd0);
      send_req(KIND_ADD, 16'h4001, 8'd2);
      send_req(KIND_LIST, 16'h0000, 8'd0);
      drain();

      write_queues(5'd31);
      no_idle = 1'b1;
      random_phase(40, 16'h30FF);
      no_idle = 1'b0;
      random_phase(60, 16'h307F);
      drain();

      write_queues(5'd0);
      random_phase(15, 16'h303F);
      drain();

      write_queues(5'd4);
      random_phase(70, 16'h004F);
      drain();

      // final wait handled by drain
      if (errors == 0)
         $display("PASS multi_queue_membership_manager");
      else
         $display("FAIL multi_queue_membership_manager");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/mqmm_pkg.sv
src/mqmm_if.sv
src/mqmm_ram.sv
src/multi_queue_membership_manager.sv
src/mqmm_checker.sv
tb/sv/tb_top.sv
